// ===== rtl/fpfla_pkg.sv =====
// types and codes shared by the fixed pool free list allocator
`timescale 1ns / 1ps

package fpfla_pkg;

  localparam int POOL_SLOTS = 8;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FULL      = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NULL      = 3'd4
  } status_t;

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_LOOKUP = 1'b1
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] slot_index;
    logic       null_ref;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] granted_slot;
    logic [3:0] free_slots;
    logic [3:0] used_count;
  } rsp_t;

endpackage

// ===== rtl/fixed_pool_free_list_allocator_core.sv =====
// fixed pool slot allocator: index-linked free list in a synchronous link table
//
// A request is transferred when start is high and busy is low. Each request first
// reads the link table synchronously at the list head, then updates the head and
// count and writes the link of a released slot. The result is shown on rsp with
// done high for exactly one cycle, the cycle after the update; busy is already low
// then, so a new request can be transferred while done is high. The receiver
// cannot stall. Reset clears the link table's valid bits at once, an entry never
// written reads as its own index plus one, so no clearing pass is needed.
`timescale 1ns / 1ps

module fixed_pool_free_list_allocator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fpfla_pkg::req_t   req,
  output logic              busy,
  output logic              done,
  output fpfla_pkg::rsp_t   rsp
);

  import fpfla_pkg::*;

  localparam int IW = $clog2(POOL_SLOTS);
  localparam int HW = $clog2(POOL_SLOTS + 1);
  localparam logic [HW-1:0] END_MARK = HW'(POOL_SLOTS);

  logic [HW-1:0]         next_free [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] nf_valid;

  state_t        state;
  state_t        state_next;
  req_t          req_q;
  logic [HW-1:0] head_slot;
  logic [HW-1:0] head_slot_next;
  logic [HW-1:0] free_total;
  logic [HW-1:0] free_total_next;
  logic [HW-1:0] rd_data;
  logic          rd_valid;
  logic [IW-1:0] rd_addr;
  logic          accept;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [HW-1:0] link;
  status_t       status;
  logic [HW-1:0] granted;

  assign accept = start && !busy;
  assign rd_en  = accept && (head_slot < END_MARK);
  assign link   = rd_valid ? rd_data : HW'(rd_addr) + HW'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state == S_LOOKUP);
  end

  // request evaluation
  always_comb begin
    status          = ST_ALLOCATED;
    granted         = '0;
    head_slot_next  = head_slot;
    free_total_next = free_total;
    wr_en           = 1'b0;
    wr_addr         = req_q.slot_index[IW-1:0];
    if (req_q.mode == MODE_ALLOC) begin
      if (head_slot >= END_MARK) begin
        status = ST_FULL;
      end else begin
        status         = ST_ALLOCATED;
        granted        = head_slot;
        head_slot_next = link;
        if (free_total != '0) free_total_next = free_total - HW'(1);
      end
    end else if (req_q.null_ref) begin
      status = ST_NULL;
    end else if ({1'b0, req_q.slot_index} >= 9'(POOL_SLOTS)) begin
      status = ST_RANGE;
    end else begin
      status         = ST_RELEASED;
      wr_en          = 1'b1;
      head_slot_next = HW'(req_q.slot_index);
      if (free_total < END_MARK) free_total_next = free_total + HW'(1);
    end
  end

  // link table
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= next_free[head_slot[IW-1:0]];
    end
    if (state == S_LOOKUP && wr_en) begin
      next_free[wr_addr] <= head_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req;
      rd_addr <= head_slot[IW-1:0];
    end
    if (state == S_LOOKUP) begin
      rsp.status       <= status;
      rsp.granted_slot <= 3'(granted);
      rsp.free_slots   <= 4'(free_total_next);
      rsp.used_count   <= 4'(END_MARK - free_total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_slot  <= '0;
      free_total <= END_MARK;
      nf_valid   <= '0;
      rd_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_LOOKUP);
      if (rd_en) begin
        rd_valid <= nf_valid[head_slot[IW-1:0]];
      end
      if (state == S_LOOKUP) begin
        head_slot  <= head_slot_next;
        free_total <= free_total_next;
        if (wr_en) nf_valid[wr_addr] <= 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= END_MARK)
    else $error("free count above pool size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("transfer not followed by lookup");

  a_lookup_done: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOKUP |=> done && !busy)
    else $error("lookup not followed by a single result");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> head_slot >= END_MARK)
    else $error("pool full reported with a nonempty list");

endmodule
